[hdl/rlm_pkg.sv]
// ----------------------------------------------------------------------------
// rlm_pkg
// shared types and constants of the rms level meter with peak detect
// ----------------------------------------------------------------------------
package rlm_pkg;

    // configuration register widths
    localparam int MID_W = 12;
    localparam int MARGIN_W = 12;
    localparam int CNT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // accumulator and result widths
    localparam int SUM_W = 41;
    localparam int RMS_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MID_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

    // reset values
    localparam logic [MID_W-1:0] MID_RST = 12'd1650;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(900 / 2);
    localparam logic [CNT_W-1:0] WINDOW_RST = 16'd2000;

    localparam logic [RMS_W-1:0] RMS_MAX = 12'd4095;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } rlm_stat_t;

endpackage

[hdl/rlm_sqmul.sv]
// ----------------------------------------------------------------------------
// rlm_sqmul
// bit-serial squarer: shift-add over one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rlm_sqmul #(
    parameter int MAG_W = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [MAG_W-1:0]       mag,
    output rlm_pkg::rlm_stat_t     stat,
    output logic [2*MAG_W-1:0]     square
);
    import rlm_pkg::*;

    localparam int CNT_BITS = $clog2(MAG_W + 1);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(MAG_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [2*MAG_W-1:0]    acc_reg;
    logic [2*MAG_W-1:0]    acc_next;
    logic [2*MAG_W-1:0]    mcand_reg;
    logic [MAG_W-1:0]      mplier_reg;

    // add the shifted multiplicand when the current multiplier bit is set
    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mcand_reg <= (2*MAG_W)'(mag);
            mplier_reg <= mag;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            mcand_reg <= {mcand_reg[2*MAG_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MAG_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign square = acc_reg;

endmodule

[hdl/rlm_div.sv]
// ----------------------------------------------------------------------------
// rlm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rlm_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUM_W-1:0]       dividend,
    input  logic [DEN_W-1:0]       divisor,
    output rlm_pkg::rlm_stat_t     stat,
    output logic [NUM_W-1:0]       quotient
);
    import rlm_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_W + 1);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(NUM_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [NUM_W-1:0]      quo_reg;
    logic [DEN_W:0]        trial;
    logic [DEN_W:0]        diff;
    logic                  fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff = trial - {1'b0, den_reg};
    assign fits = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits back in DEN_W bits
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient = quo_reg;

endmodule

[hdl/rlm_sqrt.sv]
// ----------------------------------------------------------------------------
// rlm_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module rlm_sqrt #(
    parameter int IN_W = 41
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [IN_W-1:0]                    radicand,
    output rlm_pkg::rlm_stat_t                 stat,
    output logic [(IN_W + (IN_W % 2))/2-1:0]   root
);
    import rlm_pkg::*;

    localparam int EVEN_W = IN_W + (IN_W % 2);
    localparam int ROOT_W = EVEN_W / 2;
    localparam int CNT_BITS = $clog2(ROOT_W + 1);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(ROOT_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [EVEN_W-1:0]     x_reg;
    logic [ROOT_W:0]       rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_W+2:0]     trial;
    logic [ROOT_W+2:0]     test;
    logic [ROOT_W+2:0]     diff;
    logic                  fits;

    // bring down the next bit pair and try root*4+1
    assign trial = {rem_reg, x_reg[EVEN_W-1:EVEN_W-2]};
    assign test = {1'b0, root_reg, 2'b01};
    assign diff = trial - test;
    assign fits = (trial >= test);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= EVEN_W'(radicand);
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            // remainder never exceeds twice the root, so ROOT_W+1 bits hold it
            rem_reg <= fits ? diff[ROOT_W:0] : trial[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            x_reg <= {x_reg[EVEN_W-3:0], 2'b00};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root = root_reg;

endmodule

[hdl/rms_level_meter_with_peak_core.sv]
// ----------------------------------------------------------------------------
// rms_level_meter_with_peak_core
// windowed rms level meter with peak detect, serial arithmetic datapath
// ----------------------------------------------------------------------------
//
//  channel  signals                       direction  moves
//  -------  ----------------------------  ---------  --------------------------
//  in       in_valid in_ready sample      sink       one sample per transaction
//  out      out_valid out_ready           source     rms_level and peak_flag,
//           rms_level peak_flag                      one per closed window
//  cfg      cfg_wr_en cfg_index cfg_wdata sink       register write, no wait
//
//  a sample that does not close its window passes only the shift-add squarer
//  (MAG_W = max(SAMPLE_BITS, 12)); one that closes it then passes the restoring
//  divider and the square root unit, and its result is loaded into the output
//  register. in_ready is high only between samples. a finished result waits in
//  the output register; the next sample is taken meanwhile and only a following
//  window close waits on out_ready. asynchronous reset returns the control,
//  configuration and window registers to reset values; payload is not reset.
//
module rms_level_meter_with_peak_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            sample,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rlm_pkg::RMS_W-1:0]         rms_level,
    output logic                              peak_flag,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [rlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rlm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import rlm_pkg::*;

    // offset magnitude width, the width that holds threshold sums and the root width
    localparam int MAG_W = (SAMPLE_BITS > MID_W) ? SAMPLE_BITS : MID_W;
    localparam int CMP_W = MAG_W + 1;
    localparam int ROOT_W = (SUM_W + (SUM_W % 2)) / 2;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL = 3'd1;
    localparam logic [2:0] ST_DIV = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_FIN = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;

    // configuration registers
    logic [MID_W-1:0]       mid_level_reg;
    logic [MARGIN_W-1:0]    peak_margin_reg;
    logic [CNT_W-1:0]       window_length_reg;

    // window accumulators
    logic [SUM_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic                   peak_reg;

    // output register
    logic                   out_valid_reg;
    logic [RMS_W-1:0]       rms_reg;
    logic                   flag_reg;

    logic                   in_fire;
    logic                   out_fire;
    logic                   out_load;
    logic [SAMPLE_BITS-1:0] mid_trunc;
    logic signed [MAG_W:0]  diff;
    logic [MAG_W-1:0]       mag;
    logic [2*MAG_W-1:0]     square;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [CNT_W-1:0]       win_len;
    logic                   win_close;
    logic                   peak_now;
    logic [SUM_W-1:0]       quotient;
    logic [ROOT_W-1:0]      root;
    logic [RMS_W-1:0]       rms_sat;

    rlm_stat_t              mul_stat;
    rlm_stat_t              div_stat;
    rlm_stat_t              sqrt_stat;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    // a finished result moves to the output register once it is free
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // min and max restart at the midpoint cut to the sample width
    assign mid_trunc = SAMPLE_BITS'(mid_level_reg);

    // offset from the midpoint, folded to a magnitude for the squarer
    assign diff = $signed({1'b0, MAG_W'(sample)}) - $signed({1'b0, MAG_W'(mid_level_reg)});
    assign mag = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];

    // saturating accumulate of the new square
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(square);
    assign sum_sat = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    // zero length acts as one; a lowered length closes with the next sample
    assign win_len = (window_length_reg == '0) ? CNT_W'(1) : window_length_reg;
    assign win_close = (count_reg >= win_len);

    // thresholds compared without wrap: min + margin < mid, max > mid + margin
    assign peak_now = ((CMP_W'(min_reg) + CMP_W'(peak_margin_reg)) < CMP_W'(mid_level_reg))
                   || (CMP_W'(max_reg) > (CMP_W'(mid_level_reg) + CMP_W'(peak_margin_reg)));

    assign rms_sat = (root > ROOT_W'(RMS_MAX)) ? RMS_MAX : root[RMS_W-1:0];

    rlm_sqmul #(
        .MAG_W(MAG_W)
    ) u_sqmul (
        .clk(clk),
        .rst_n(rst_n),
        .start(in_fire),
        .mag(mag),
        .stat(mul_stat),
        .square(square)
    );

    rlm_div #(
        .NUM_W(SUM_W),
        .DEN_W(CNT_W)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(mul_stat.done && win_close),
        .dividend(sum_sat),
        .divisor(count_reg),
        .stat(div_stat),
        .quotient(quotient)
    );

    rlm_sqrt #(
        .IN_W(SUM_W)
    ) u_sqrt (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_stat.done),
        .radicand(quotient),
        .stat(sqrt_stat),
        .root(root)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = win_close ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mid_level_reg <= MID_RST;
            peak_margin_reg <= MARGIN_RST;
            window_length_reg <= WINDOW_RST;
            sum_reg <= '0;
            count_reg <= '0;
            min_reg <= SAMPLE_BITS'(MID_RST);
            max_reg <= SAMPLE_BITS'(MID_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes; an index past the list is dropped
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MID_LEVEL:     mid_level_reg <= cfg_wdata[MID_W-1:0];
                    REG_PEAK_MARGIN:   peak_margin_reg <= cfg_wdata[MARGIN_W-1:0];
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata[CNT_W-1:0];
                    default:           ;
                endcase
            end

            // min, max and count move as the sample is taken
            if (in_fire)
            begin
                count_reg <= count_reg + 1'b1;
                if (sample < min_reg)
                begin
                    min_reg <= sample;
                end
                if (sample > max_reg)
                begin
                    max_reg <= sample;
                end
            end

            // square is ready: accumulate or close the window
            if (mul_stat.done)
            begin
                if (win_close)
                begin
                    sum_reg <= '0;
                    count_reg <= '0;
                    min_reg <= mid_trunc;
                    max_reg <= mid_trunc;
                end
                else
                begin
                    sum_reg <= sum_sat;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (mul_stat.done && win_close)
        begin
            peak_reg <= peak_now;
        end
        if (sqrt_stat.done)
        begin
            rms_reg <= rms_sat;
        end
        if (out_load)
        begin
            flag_reg <= peak_reg;
        end
    end

    // the output takes the saturated root captured when the root unit finished
    logic [RMS_W-1:0] rms_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rms_out_reg <= rms_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign rms_level = rms_out_reg;
    assign peak_flag = flag_reg;

    // no arithmetic unit runs while a new sample may be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(mul_stat.busy || div_stat.busy || sqrt_stat.busy))
        else $error("arithmetic unit busy while accepting samples");

    // a taken sample always starts the squarer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_MUL) && mul_stat.busy)
        else $error("sample taken without starting the squarer");

    // the divider finishes only in its own phase of the sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its phase");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

endmodule
